@@ rtl/pqwm_pkg.sv @@
// shared types, codes and constants for the priority queue with watermarks
package pqwm_pkg;

    // field widths fixed by the interface
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int WORD_W    = 32;
    localparam int PRIO_W    = 32;
    localparam int OCC_W     = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // parameter defaults
    localparam int CAPACITY_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // reset values of the watermark registers
    localparam logic [CFG_W-1:0] MAX_SIZE_RST  = CFG_W'(16);
    localparam logic [CFG_W-1:0] HIGH_MARK_RST = CFG_W'(16);
    localparam logic [CFG_W-1:0] LOW_MARK_RST  = CFG_W'(0);

    // operation carried by an input item
    typedef enum logic [KIND_W-1:0] {
        KIND_PUT  = 2'd0,
        KIND_GET  = 2'd1,
        KIND_RUN  = 2'd2,
        KIND_STOP = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_STOPPED      = 3'd1,
        ST_HWM          = 3'd2,
        ST_NO_SPACE     = 3'd3,
        ST_EMPTY        = 3'd4,
        ST_CONFIG_ERROR = 3'd5
    } t_status;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SIZE  = 2'd0,
        CFG_HIGH_MARK = 2'd1,
        CFG_LOW_MARK  = 2'd2
    } t_cfg_idx;

    // command broadcast to every cell of the sorted chain
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_op;

endpackage

@@ rtl/pqwm_cell.sv @@
// one slot of the sorted chain: holds an entry, shifts right on insert, left on remove
module pqwm_cell #(
    parameter int PW = pqwm_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              i_clk,
    input  pqwm_pkg::t_cell_op                i_op,
    input  logic signed [pqwm_pkg::PRIO_W-1:0] i_new_key,
    input  logic [PW-1:0]                     i_new_pay,
    input  logic                              i_occupied,
    input  logic                              i_left_keep,
    input  logic signed [pqwm_pkg::PRIO_W-1:0] i_left_key,
    input  logic [PW-1:0]                     i_left_pay,
    input  logic signed [pqwm_pkg::PRIO_W-1:0] i_right_key,
    input  logic [PW-1:0]                     i_right_pay,
    output logic                              o_keep,
    output logic signed [pqwm_pkg::PRIO_W-1:0] o_key,
    output logic [PW-1:0]                     o_pay
);
    import pqwm_pkg::*;

    logic signed [PRIO_W-1:0] r_key;
    logic signed [PRIO_W-1:0] n_key;
    logic [PW-1:0]            r_pay;
    logic [PW-1:0]            n_pay;

    // entry stays put when it is at least as urgent as the newcomer (older wins ties)
    assign o_keep = i_occupied && (r_key >= i_new_key);
    assign o_key  = r_key;
    assign o_pay  = r_pay;

    // next entry: hold, take the newcomer, take the left neighbor or the right one
    always_comb begin
        n_key = r_key;
        n_pay = r_pay;
        if (i_op.insert) begin
            if (!o_keep) begin
                if (i_left_keep) begin
                    n_key = i_new_key;
                    n_pay = i_new_pay;
                end else begin
                    n_key = i_left_key;
                    n_pay = i_left_pay;
                end
            end
        end else if (i_op.remove) begin
            n_key = i_right_key;
            n_pay = i_right_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
    end

endmodule

@@ rtl/priority_queue_with_watermarks_unit.sv @@
// top level of the bounded priority queue with watermarks
//
//  channel  | direction | handshake                     | content
//  ---------+-----------+-------------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | kind, payload, priority_req
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | status, payload_out, events,
//           |           |                               | occupancy
//  cfg      | in        | i_cfg_valid / o_cfg_ready     | register index, write data
//
// the cell chain inserts or removes in parallel in the cycle of the transfer, and the
// result is in the output register on the next cycle. one item per cycle is sustained;
// input stalls only while the output register holds a result that the sink has not taken.
// reset loads the watermark registers with their reset values and clears the fill count,
// the running flag and the output valid flag; the cell contents need no clearing since
// only occupied cells are read.
module priority_queue_with_watermarks_unit #(
    parameter int CAPACITY     = pqwm_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = pqwm_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // payload[31:0], priority_req[63:32]
    input  logic [pqwm_pkg::KIND_W-1:0]       s_axis_tuser,  // kind[1:0]
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [47:0]                       m_axis_tdata,  // payload_out[31:0], hwm_event[32],
                                                             // lwm_event[33], start_event[34],
                                                             // stop_event[35], occupancy[40:36],
                                                             // zero[47:41]
    output logic [pqwm_pkg::STATUS_W-1:0]     m_axis_tuser,  // status[2:0]
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pqwm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pqwm_pkg::CFG_W-1:0]        i_cfg_data
);
    import pqwm_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int PW    = (PAYLOAD_BITS < WORD_W) ? PAYLOAD_BITS : WORD_W;

    // configuration and control state
    logic [CFG_W-1:0] r_max_size;
    logic [CFG_W-1:0] r_high_mark;
    logic [CFG_W-1:0] r_low_mark;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic             r_running;
    logic             n_running;

    // output register
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    logic [WORD_W-1:0] r_pout;
    logic [WORD_W-1:0] n_pout;
    logic             r_hwm, n_hwm;
    logic             r_lwm, n_lwm;
    logic             r_start, n_start;
    logic             r_stop, n_stop;

    logic             in_xfer;
    t_kind            kind;
    logic signed [PRIO_W-1:0] new_key;
    logic [PW-1:0]    new_pay;
    logic             cfg_bad;
    t_cell_op         op;
    logic [CMP_W-1:0] fill_x;
    logic [CNT_W-1:0] fill_dec;

    // chain wiring
    logic                     keep    [CAPACITY];
    logic signed [PRIO_W-1:0] key_q   [CAPACITY];
    logic [PW-1:0]            pay_q   [CAPACITY];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign kind    = t_kind'(s_axis_tuser);
    assign new_pay = s_axis_tdata[PW-1:0];
    assign new_key = s_axis_tdata[63:32];

    assign fill_x   = CMP_W'(r_fill);
    assign fill_dec = r_fill - CNT_W'(1);

    // watermark settings that would be rejected at creation
    assign cfg_bad = (r_high_mark > r_max_size) || (r_low_mark > r_max_size) ||
                     (r_high_mark < r_low_mark) ||
                     (CMP_W'(r_max_size) > CMP_W'(CAPACITY));

    // operation decode and result
    always_comb begin
        op        = '0;
        n_fill    = r_fill;
        n_running = r_running;
        n_status  = ST_OK;
        n_pout    = '0;
        n_hwm     = 1'b0;
        n_lwm     = 1'b0;
        n_start   = 1'b0;
        n_stop    = 1'b0;
        unique case (kind)
            KIND_RUN: begin
                if (!r_running) begin
                    n_running = 1'b1;
                    n_start   = 1'b1;
                end
            end
            KIND_STOP: begin
                if (r_running) begin
                    n_running = 1'b0;
                    n_stop    = 1'b1;
                end
            end
            KIND_PUT: begin
                if (cfg_bad) begin
                    n_status = ST_CONFIG_ERROR;
                end else if (!r_running) begin
                    n_status = ST_STOPPED;
                end else if ((fill_x >= CMP_W'(r_high_mark)) ||
                             (fill_x >= CMP_W'(CAPACITY))) begin
                    n_hwm    = 1'b1;
                    n_status = (fill_x >= CMP_W'(r_max_size)) ? ST_NO_SPACE : ST_HWM;
                end else begin
                    op.insert = in_xfer;
                    n_fill    = r_fill + CNT_W'(1);
                end
            end
            KIND_GET: begin
                if (cfg_bad) begin
                    n_status = ST_CONFIG_ERROR;
                end else if (!r_running) begin
                    n_status = ST_STOPPED;
                end else if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    op.remove = in_xfer;
                    n_pout    = WORD_W'(pay_q[0]);
                    n_fill    = fill_dec;
                    n_lwm     = CMP_W'(fill_dec) <= CMP_W'(r_low_mark);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // sorted cell chain, most urgent entry in cell 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                     left_keep;
        logic signed [PRIO_W-1:0] left_key;
        logic [PW-1:0]            left_pay;
        logic signed [PRIO_W-1:0] right_key;
        logic [PW-1:0]            right_pay;

        if (i == 0) begin : g_head
            assign left_keep = 1'b1;
            assign left_key  = '0;
            assign left_pay  = '0;
        end else begin : g_body
            assign left_keep = keep[i-1];
            assign left_key  = key_q[i-1];
            assign left_pay  = pay_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_key = '0;
            assign right_pay = '0;
        end else begin : g_inner
            assign right_key = key_q[i+1];
            assign right_pay = pay_q[i+1];
        end

        pqwm_cell #(
            .PW (PW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (op),
            .i_new_key   (new_key),
            .i_new_pay   (new_pay),
            .i_occupied  (r_fill > CNT_W'(i)),
            .i_left_keep (left_keep),
            .i_left_key  (left_key),
            .i_left_pay  (left_pay),
            .i_right_key (right_key),
            .i_right_pay (right_pay),
            .o_keep      (keep[i]),
            .o_key       (key_q[i]),
            .o_pay       (pay_q[i])
        );
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size  <= MAX_SIZE_RST;
            r_high_mark <= HIGH_MARK_RST;
            r_low_mark  <= LOW_MARK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_SIZE:  r_max_size  <= i_cfg_data;
                CFG_HIGH_MARK: r_high_mark <= i_cfg_data;
                CFG_LOW_MARK:  r_low_mark  <= i_cfg_data;
                default:       r_max_size  <= r_max_size;
            endcase
        end
    end

    // queue control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_running <= 1'b0;
        end else if (in_xfer) begin
            r_fill    <= n_fill;
            r_running <= n_running;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status <= n_status;
            r_pout   <= n_pout;
            r_hwm    <= n_hwm;
            r_lwm    <= n_lwm;
            r_start  <= n_start;
            r_stop   <= n_stop;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {7'd0, OCC_W'(r_fill), r_stop, r_start, r_lwm, r_hwm, r_pout};

    // fill count never passes the number of cells
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_fill) <= CMP_W'(CAPACITY))
        else $error("fill count above capacity");

    // reported occupancy tracks the fill count while a result waits
    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (m_axis_tdata[40:36] == OCC_W'(r_fill)))
        else $error("occupancy field differs from fill count");

    // a stopped queue keeps its contents on put and get
    a_stopped_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !r_running && (kind == KIND_PUT || kind == KIND_GET)) |=>
            $stable(r_fill))
        else $error("stopped queue changed its fill count");

    // only a successful get carries a payload word
    a_pout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_pout == '0))
        else $error("payload on a failed operation");

    // insert and remove never happen together
    a_op_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(op.insert && op.remove))
        else $error("insert and remove in one cycle");

endmodule

@@ tb/sv/tb_priority_queue_with_watermarks_unit.sv @@
// self-checking testbench for the priority queue with watermarks, checked against a queue model
module tb_priority_queue_with_watermarks_unit;
    import pqwm_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int PHASES        = 10;
    localparam int OPS_PER_PHASE = 55;
    localparam int IDLE_PCT      = 22;

    // one queued message, kept in arrival order
    typedef struct {
        logic [WORD_W-1:0]        word;
        logic signed [PRIO_W-1:0] prio;
    } t_queued_msg;

    // one result of the queue, as it leaves the output channel
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   word;
        logic                hwm;
        logic                lwm;
        logic                start_ev;
        logic                stop_ev;
        logic [OCC_W-1:0]    occ;
        logic [6:0]          pad;
    } t_queue_result;

    // queue model: predicts each result and checks what the block returns
    class t_pqwm_tracker;
        logic [CFG_W-1:0] max_size;
        logic [CFG_W-1:0] high_mark;
        logic [CFG_W-1:0] low_mark;
        bit               running;
        t_queued_msg      held[$];
        t_queue_result    pending_results[$];
        int               mismatches;
        int               results_checked;

        function new();
            max_size        = MAX_SIZE_RST;
            high_mark       = HIGH_MARK_RST;
            low_mark        = LOW_MARK_RST;
            running         = 1'b0;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_MAX_SIZE:  max_size  = value;
                CFG_HIGH_MARK: high_mark = value;
                CFG_LOW_MARK:  low_mark  = value;
                default: ;
            endcase
        endfunction

        // note an accepted operation and queue its expected result
        function void take_op(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word,
                              logic [PRIO_W-1:0] prio);
            t_queue_result r;
            t_queued_msg   m;
            int            best;
            bit            marks_bad;
            r          = '0;
            r.status   = ST_OK;
            marks_bad  = (high_mark > max_size) || (low_mark > max_size) ||
                         (high_mark < low_mark) || (max_size > CAPACITY_DEF);
            case (kind)
                KIND_RUN: begin
                    if (!running) begin
                        running    = 1'b1;
                        r.start_ev = 1'b1;
                    end
                end
                KIND_STOP: begin
                    if (running) begin
                        running   = 1'b0;
                        r.stop_ev = 1'b1;
                    end
                end
                default: begin
                    if (marks_bad) begin
                        r.status = ST_CONFIG_ERROR;
                    end else if (!running) begin
                        r.status = ST_STOPPED;
                    end else if (kind == KIND_PUT) begin
                        // refused at the high mark; no space once at max_size
                        if (held.size() >= high_mark || held.size() >= CAPACITY_DEF) begin
                            r.hwm    = 1'b1;
                            r.status = (held.size() >= max_size) ? ST_NO_SPACE : ST_HWM;
                        end else begin
                            m.word = word;
                            m.prio = prio;
                            held   = {held, m};
                        end
                    end else if (held.size() == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        // highest priority wins, the oldest among equals
                        best = 0;
                        for (int i = 1; i < held.size(); i++)
                            if (held[i].prio > held[best].prio)
                                best = i;
                        r.word = held[best].word;
                        held.delete(best);
                        if (held.size() <= low_mark)
                            r.lwm = 1'b1;
                    end
                end
            endcase
            r.occ = OCC_W'(held.size());
            pending_results = {pending_results, r};
        endfunction

        function void report(string why, t_queue_result want, t_queue_result got);
            mismatches++;
            if (mismatches <= 10)
                $display({"result %0d %s: expected status=%0d word=%h ",
                          "hwm/lwm/start/stop=%b%b%b%b occ=%0d"},
                         results_checked, why, want.status, want.word, want.hwm, want.lwm,
                         want.start_ev, want.stop_ev, want.occ,
                         "\n    got status=%0d word=%h hwm/lwm/start/stop=%b%b%b%b occ=%0d pad=%h",
                         got.status, got.word, got.hwm, got.lwm, got.start_ev, got.stop_ev,
                         got.occ, got.pad);
        endfunction

        // compare an accepted result with the oldest expectation
        function void match_result(logic [47:0] data, logic [STATUS_W-1:0] status);
            t_queue_result want;
            t_queue_result got;
            got.status   = status;
            got.word     = data[31:0];
            got.hwm      = data[32];
            got.lwm      = data[33];
            got.start_ev = data[34];
            got.stop_ev  = data[35];
            got.occ      = data[40:36];
            got.pad      = data[47:41];
            results_checked++;
            if (pending_results.size() == 0) begin
                report("with nothing expected", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.word !== want.word ||
                    got.hwm !== want.hwm || got.lwm !== want.lwm ||
                    got.start_ev !== want.start_ev || got.stop_ev !== want.stop_ev ||
                    got.occ !== want.occ || got.pad !== want.pad)
                    report("mismatch", want, got);
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata  = '0;
    logic [KIND_W-1:0]    s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    t_pqwm_tracker tracker = new();
    bit            steady  = 1'b0;
    int            ops_sent = 0;
    int            cycle_count = 0;

    priority_queue_with_watermarks_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watch every transfer on the three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                tracker.write_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_op(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // result sink with random stalls
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // present one operation, with random gaps before it
    task automatic send_op(t_kind kind, logic [WORD_W-1:0] word, logic [PRIO_W-1:0] prio);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {prio, word};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        ops_sent++;
    endtask

    // one register write; valid stays high for a following write
    task automatic cfg_write(t_cfg_idx idx, logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task automatic set_marks(logic [CFG_W-1:0] mx, logic [CFG_W-1:0] hi, logic [CFG_W-1:0] lo);
        cfg_write(CFG_MAX_SIZE, mx);
        cfg_write(CFG_HIGH_MARK, hi);
        cfg_write(CFG_LOW_MARK, lo);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every result has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.results_checked < ops_sent)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // run limit
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int               put_pct;
        int               r;
        logic [CFG_W-1:0] mx;
        logic [CFG_W-1:0] hi;
        logic [CFG_W-1:0] lo;
        logic [PRIO_W-1:0] prio_val;
        t_kind            kind_sel;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stopped after reset, redundant stop and run, get on empty queue
        send_op(KIND_PUT, 32'h1111_1111, 32'd7);
        send_op(KIND_GET, 32'h0, 32'h0);
        send_op(KIND_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(KIND_RUN, 32'h0, 32'h0);
        send_op(KIND_RUN, 32'h0, 32'h0);
        send_op(KIND_GET, 32'h0, 32'h0);

        // priority extremes and a tie, drained down to the low mark
        send_op(KIND_PUT, 32'h0000_0000, 32'h8000_0000);
        send_op(KIND_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_op(KIND_PUT, 32'h1234_5678, 32'h0000_0000);
        send_op(KIND_PUT, 32'h8765_4321, 32'h0000_0000);
        send_op(KIND_PUT, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
        repeat (5) send_op(KIND_GET, $urandom, $urandom);

        // put refused at the high mark below max_size
        wait_idle();
        set_marks(5'd4, 5'd2, 5'd1);
        repeat (3) send_op(KIND_PUT, $urandom, $urandom);

        // max_size lowered below the fill, then a put and a get
        wait_idle();
        set_marks(5'd1, 5'd1, 5'd0);
        send_op(KIND_PUT, $urandom, $urandom);
        send_op(KIND_GET, $urandom, $urandom);

        // high mark above max_size: put and get rejected, run and stop still work
        wait_idle();
        set_marks(5'd1, 5'd3, 5'd0);
        send_op(KIND_PUT, $urandom, $urandom);
        send_op(KIND_STOP, $urandom, $urandom);
        send_op(KIND_GET, $urandom, $urandom);
        send_op(KIND_RUN, $urandom, $urandom);

        // random phases, each under its own watermark setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin mx = 5'd16; hi = 5'd16; lo = 5'd0;  end
                2: begin mx = 5'd16; hi = 5'd16; lo = 5'd16; end
                3: begin mx = 5'd0;  hi = 5'd0;  lo = 5'd0;  end
                5: begin mx = 5'd31; hi = 5'd16; lo = 5'd0;  end
                6: begin mx = 5'd8;  hi = 5'd4;  lo = 5'd6;  end
                8: begin
                    mx = CFG_W'($urandom);
                    hi = CFG_W'($urandom);
                    lo = CFG_W'($urandom);
                end
                9: begin mx = 5'd16; hi = 5'd8;  lo = 5'd4;  end
                default: begin
                    mx = CFG_W'($urandom_range(0, 16));
                    hi = CFG_W'($urandom_range(0, mx));
                    lo = CFG_W'($urandom_range(0, hi));
                end
            endcase
            wait_idle();
            set_marks(mx, hi, lo);
            steady  = (ph == 4);
            put_pct = $urandom_range(35, 75);
            for (int n = 0; n < OPS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    kind_sel = KIND_RUN;
                else if (r < 10)
                    kind_sel = KIND_STOP;
                else if ($urandom_range(0, 99) < put_pct)
                    kind_sel = KIND_PUT;
                else
                    kind_sel = KIND_GET;
                // small values give many ties, extremes test the signed order
                case ($urandom_range(0, 3))
                    0: prio_val = PRIO_W'($urandom_range(0, 6)) - 32'd3;
                    1: begin
                        case ($urandom_range(0, 3))
                            0: prio_val = 32'h8000_0000;
                            1: prio_val = 32'h7FFF_FFFF;
                            2: prio_val = 32'h0000_0000;
                            default: prio_val = 32'hFFFF_FFFF;
                        endcase
                    end
                    default: prio_val = $urandom;
                endcase
                send_op(kind_sel, $urandom, prio_val);
            end
        end
        steady = 1'b0;

        wait_idle();
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pqwm_pkg.sv
rtl/pqwm_cell.sv
rtl/priority_queue_with_watermarks_unit.sv
tb/sv/tb_priority_queue_with_watermarks_unit.sv
